// ===== sv/ccm_pkg.sv =====
// ----------------------------------------------------------------------------
// ccm_pkg
// shared types and codes for the cigar coverage marker
// ----------------------------------------------------------------------------
`default_nettype none

package ccm_pkg;

    // request opcodes
    localparam logic OP_ELEMENT = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;

    // cigar operation codes
    localparam logic [3:0] CIGAR_M  = 4'd0;
    localparam logic [3:0] CIGAR_I  = 4'd1;
    localparam logic [3:0] CIGAR_D  = 4'd2;
    localparam logic [3:0] CIGAR_N  = 4'd3;
    localparam logic [3:0] CIGAR_S  = 4'd4;
    localparam logic [3:0] CIGAR_H  = 4'd5;
    localparam logic [3:0] CIGAR_P  = 4'd6;
    localparam logic [3:0] CIGAR_EQ = 4'd7;
    localparam logic [3:0] CIGAR_X  = 4'd8;

    // register index of the target length on the config port
    localparam logic CFG_TARGET_LEN = 1'b0;
    localparam logic [14:0] TARGET_LEN_RST = 15'd16384;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SETUP,
        S_RD,
        S_MOD,
        S_RESP
    } t_ccm_state;

    typedef struct packed {
        logic accept;
        logic clr_step;
        logic setup;
        logic rd;
        logic mod;
        logic resp;
    } t_ccm_cmd;

    typedef struct packed {
        logic empty;
        logic clr_last;
    } t_ccm_sts;

endpackage

`default_nettype wire

// ===== sv/ccm_ram.sv =====
// ----------------------------------------------------------------------------
// ccm_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/ccm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ccm_ctrl
// sequencer for clear sweep and word-by-word run marking
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_ctrl
    import ccm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic     i_op,
    input  wire t_ccm_sts i_sts,
    output t_ccm_cmd      o_cmd,
    output logic          o_busy
);

    t_ccm_state r_state, n_state;
    logic       r_report, n_report;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_report <= n_report;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_report = r_report;
        case (r_state)
            S_CLR: begin
                if (i_sts.clr_last) begin
                    n_state = r_report ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == OP_CLEAR) begin
                        n_state  = S_CLR;
                        n_report = 1'b1;
                    end else begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: n_state = S_RD;
            S_RD: begin
                n_state = i_sts.empty ? S_RESP : S_MOD;
            end
            S_MOD: n_state = S_RD;
            S_RESP: begin
                n_state  = S_IDLE;
                n_report = 1'b0;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_busy         = 1'b1;
        case (r_state)
            S_CLR:   o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            S_SETUP: o_cmd.setup = 1'b1;
            S_RD:    o_cmd.rd    = !i_sts.empty;
            S_MOD:   o_cmd.mod   = 1'b1;
            S_RESP:  o_cmd.resp  = 1'b1;
            default: o_busy      = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/ccm_dpath.sv =====
// ----------------------------------------------------------------------------
// ccm_dpath
// cursor, counters, bitmap word update and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ccm_dpath
    import ccm_pkg::*;
#(
    parameter int MAX_BASES = 16384
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_ccm_cmd    i_cmd,
    output t_ccm_sts         o_sts,
    input  wire logic [14:0] i_target_len,
    input  wire logic        i_op,
    input  wire logic        i_first_element,
    input  wire logic [14:0] i_start_pos,
    input  wire logic [3:0]  i_cigar_code,
    input  wire logic [14:0] i_run_length,
    output logic             o_result_valid,
    output logic [14:0]      o_covered_bases,
    output logic [31:0]      o_read_hits
);

    localparam int WORDS = (MAX_BASES + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int XW    = (AW > 11) ? AW : 11;
    localparam logic [20:0] MAXB = 21'(MAX_BASES);

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int k = 0; k < 8; k++) begin
            c = c + {3'b0, v[k]};
        end
        return c;
    endfunction

    logic [14:0] r_cursor;
    logic [14:0] r_cov;
    logic [31:0] r_hits;
    logic [15:0] r_pos;
    logic [15:0] r_end;
    logic [14:0] r_run;
    logic        r_mark;
    logic        r_move;
    logic [5:0]  r_pop;
    logic        r_pop_vld;
    logic [AW-1:0] r_clr_addr;
    logic        r_out_valid;
    logic [14:0] r_out_cov;
    logic [31:0] r_out_hits;

    logic [14:0] base;
    logic [14:0] lim;
    logic [15:0] sum;
    logic [15:0] end_cap;
    logic [XW-1:0] word_ext;
    logic [AW-1:0] ram_addr;
    logic        ram_we;
    logic [31:0] ram_wdata;
    logic [31:0] ram_rdata;
    logic [31:0] m_lo, m_hi, mask, fresh;
    logic [5:0]  fresh_cnt;
    logic        clr_last;

    // start position is 1-based, zero acts as one
    assign base = i_first_element ? ((i_start_pos == 15'd0) ? 15'd0 : i_start_pos - 15'd1)
                                  : r_cursor;

    assign lim = ({6'b0, i_target_len} > MAXB) ? MAXB[14:0] : i_target_len;
    assign sum = r_pos + {1'b0, r_run};
    assign end_cap = (sum > {1'b0, lim}) ? {1'b0, lim} : sum;

    assign m_lo  = 32'hFFFF_FFFF << r_pos[4:0];
    assign m_hi  = (r_end[15:5] == r_pos[15:5]) ? ~(32'hFFFF_FFFF << r_end[4:0])
                                                : 32'hFFFF_FFFF;
    assign mask  = m_lo & m_hi;
    assign fresh = mask & ~ram_rdata;
    assign fresh_cnt = 6'(pop8(fresh[7:0])) + 6'(pop8(fresh[15:8]))
                     + 6'(pop8(fresh[23:16])) + 6'(pop8(fresh[31:24]));

    assign word_ext  = XW'(r_pos[15:5]);
    assign ram_addr  = i_cmd.clr_step ? r_clr_addr : word_ext[AW-1:0];
    assign ram_we    = i_cmd.clr_step | i_cmd.mod;
    assign ram_wdata = i_cmd.clr_step ? 32'd0 : (ram_rdata | mask);
    assign clr_last  = (r_clr_addr == AW'(WORDS - 1));

    ccm_ram #(
        .WIDTH (32),
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (i_cmd.rd),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor    <= '0;
            r_cov       <= '0;
            r_hits      <= '0;
            r_pop_vld   <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.resp;
            r_pop_vld   <= i_cmd.mod;
            if (i_cmd.clr_step) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + AW'(1);
            end
            if (i_cmd.accept) begin
                if (i_op == OP_CLEAR) begin
                    r_cursor <= '0;
                    r_cov    <= '0;
                    r_hits   <= '0;
                end else begin
                    r_cursor <= base;
                    if (i_first_element && r_hits != 32'hFFFF_FFFF) begin
                        r_hits <= r_hits + 32'd1;
                    end
                end
            end else if (r_pop_vld) begin
                r_cov <= r_cov + {9'b0, r_pop};
            end
            // cursor saturates at the top of its range
            if (i_cmd.setup && (r_mark || r_move)) begin
                r_cursor <= sum[15] ? 15'h7FFF : sum[14:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pos  <= {1'b0, base};
            r_run  <= i_run_length;
            r_mark <= (i_cigar_code == CIGAR_M) || (i_cigar_code == CIGAR_EQ)
                   || (i_cigar_code == CIGAR_X);
            r_move <= (i_cigar_code == CIGAR_D) || (i_cigar_code == CIGAR_N);
        end
        if (i_cmd.setup) begin
            r_end <= r_mark ? end_cap : r_pos;
        end
        if (i_cmd.mod) begin
            r_pos <= {r_pos[15:5] + 11'd1, 5'b0};
            r_pop <= fresh_cnt;
        end
        if (i_cmd.resp) begin
            r_out_cov  <= r_cov;
            r_out_hits <= r_hits;
        end
    end

    assign o_sts.empty    = (r_pos >= r_end);
    assign o_sts.clr_last = clr_last;

    assign o_result_valid  = r_out_valid;
    assign o_covered_bases = r_out_cov;
    assign o_read_hits     = r_out_hits;

endmodule

`default_nettype wire

// ===== sv/cigar_coverage_marker_core.sv =====
// ----------------------------------------------------------------------------
// cigar_coverage_marker_core
// per-base gene coverage marking from cigar elements
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one result: o_result_valid pulses for one cycle, in the first cycle
// that busy is low again, carrying the covered base count and the read hit
// count; the receiver cannot stall it, so it must sample on that cycle. An
// element that marks bases (M, = and X) keeps busy high through setup, a
// read-modify-write of each 32-bit bitmap word its run touches inside the gene
// (at most MAX_BASES/32 words, 512 at the default size, for a full-length run)
// on the single bitmap memory port, and the response; every other element
// touches no word. A clear request sweeps the bitmap one word a cycle. After
// reset the same sweep runs with busy high and no result; configuration
// writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module cigar_coverage_marker_core
    import ccm_pkg::*;
#(
    parameter int MAX_BASES = 16384
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_op,
    input  wire logic        i_first_element,
    input  wire logic [14:0] i_start_pos,
    input  wire logic [3:0]  i_cigar_code,
    input  wire logic [14:0] i_run_length,
    // result channel
    output logic             o_result_valid,
    output logic [14:0]      o_covered_bases,
    output logic [31:0]      o_read_hits,
    // config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_ccm_cmd    cmd;
    t_ccm_sts    sts;
    logic [14:0] r_target_len;
    logic        cfg_wr;

    // config register, word address decode on paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_len <= TARGET_LEN_RST;
        end else if (cfg_wr && paddr[2] == CFG_TARGET_LEN) begin
            r_target_len <= pwdata[14:0];
        end
    end

    assign prdata = (paddr[2] == CFG_TARGET_LEN) ? {17'b0, r_target_len} : 32'd0;

    // sequencer: clear sweep, then per-element setup and word loop
    ccm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // cursor, counters and bitmap memory
    ccm_dpath #(
        .MAX_BASES (MAX_BASES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_target_len    (r_target_len),
        .i_op            (i_op),
        .i_first_element (i_first_element),
        .i_start_pos     (i_start_pos),
        .i_cigar_code    (i_cigar_code),
        .i_run_length    (i_run_length),
        .o_result_valid  (o_result_valid),
        .o_covered_bases (o_covered_bases),
        .o_read_hits     (o_read_hits)
    );

    // the bitmap sweep starts right out of reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("block not busy during post-reset clear sweep");

    // a taken request keeps the block busy until its result is out
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after a request was taken");

    // a result follows a busy cycle and lasts one cycle
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy) && !busy)
        else $error("result strobe not aligned to end of request");

    a_result_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the cigar coverage marker core
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver on the start/busy
// handshake. A clocked monitor watches the same handshake. For every accepted
// request it runs a bit-accurate coverage predictor and keeps the expected
// covered-base and read-hit counts. Each result strobe is checked against the
// oldest of them. The run is a directed opening, then random reads at several
// gene lengths and sender idle rates. The target length is changed over the
// APB port only between phases, once every result is in, and is read back
// each time.
// ----------------------------------------------------------------------------

module testbench;

    import ccm_pkg::*;

    localparam int MAX_BASES      = 16384;
    localparam int CURSOR_SAT     = 32767;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [2:0] TARGET_LEN_ADDR = {CFG_TARGET_LEN, 2'b00};

    typedef struct {
        logic        op;
        logic        first;
        logic [14:0] start_pos;
        logic [3:0]  code;
        logic [14:0] run;
    } t_cigar_req;

    typedef struct {
        logic [14:0] covered;
        logic [31:0] hits;
    } t_coverage;

    // clock, reset and every block input start at a known value
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic        i_op            = 1'b0;
    logic        i_first_element = 1'b0;
    logic [14:0] i_start_pos     = '0;
    logic [3:0]  i_cigar_code    = '0;
    logic [14:0] i_run_length    = '0;
    logic        psel            = 1'b0;
    logic        penable         = 1'b0;
    logic        pwrite          = 1'b0;
    logic [2:0]  paddr           = '0;
    logic [31:0] pwdata          = '0;

    logic        busy;
    logic        o_result_valid;
    logic [14:0] o_covered_bases;
    logic [31:0] o_read_hits;
    logic [31:0] prdata;
    logic        pready;

    // request queue and the counts still owed by the block
    t_cigar_req  pending_reqs[$];
    t_coverage   owed_counts[$];
    t_cigar_req  next_req;
    t_coverage   seen_counts;
    int          idle_pct = 0;
    int          n_fail   = 0;
    int          quiet_cycles = 0;

    // shadow copy of the block state
    bit          base_marked [0:MAX_BASES-1];
    logic [14:0] gene_len = TARGET_LEN_RST;
    int          cursor   = 0;
    int          covered  = 0;
    logic [31:0] hits     = '0;

    cigar_coverage_marker_core #(
        .MAX_BASES(MAX_BASES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_first_element(i_first_element),
        .i_start_pos    (i_start_pos),
        .i_cigar_code   (i_cigar_code),
        .i_run_length   (i_run_length),
        .o_result_valid (o_result_valid),
        .o_covered_bases(o_covered_bases),
        .o_read_hits    (o_read_hits),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // coverage predictor
    // ------------------------------------------------------------------------

    // cursor saturates well past any markable base
    function automatic void step_cursor(input int run);
        cursor = (cursor + run > CURSOR_SAT) ? CURSOR_SAT : cursor + run;
    endfunction

    function automatic t_coverage mark_coverage(input t_cigar_req r);
        t_coverage res;
        int        limit;
        int        stop;
        int        p;
        if (r.op == OP_CLEAR) begin
            // other fields are don't-care on a clear
            foreach (base_marked[i]) base_marked[i] = 1'b0;
            cursor  = 0;
            covered = 0;
            hits    = '0;
        end else begin
            if (r.first) begin
                // 1-based start, zero treated as the first base
                cursor = (r.start_pos == 0) ? 0 : int'(r.start_pos) - 1;
                if (hits != '1) hits = hits + 1;
            end
            case (r.code)
                CIGAR_M, CIGAR_EQ, CIGAR_X: begin
                    // only bases below min(gene_len, MAX_BASES) get marked
                    limit = (gene_len > MAX_BASES) ? MAX_BASES : int'(gene_len);
                    stop  = cursor + int'(r.run);
                    if (stop > limit) stop = limit;
                    for (p = cursor; p < stop; p++) begin
                        if (!base_marked[p]) begin
                            base_marked[p] = 1'b1;
                            covered++;
                        end
                    end
                    step_cursor(r.run);
                end
                CIGAR_D, CIGAR_N: step_cursor(r.run);
                // I, S, H, P and unused codes leave everything alone
                default: ;
            endcase
        end
        res.covered = covered[14:0];
        res.hits    = hits;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // driver: holds a request until the edge where busy is low, then loads the
    // next one or drops start, with random idle gaps between requests
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_req = pending_reqs.pop_front();
                start           <= 1'b1;
                i_op            <= next_req.op;
                i_first_element <= next_req.first;
                i_start_pos     <= next_req.start_pos;
                i_cigar_code    <= next_req.code;
                i_run_length    <= next_req.run;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: a result strobed at this edge always belongs to an earlier
    // request, so it is checked before the request taken at this edge is added
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) begin
                if (owed_counts.size() == 0) begin
                    $error("result with no request outstanding: covered_bases %0d read_hits %0d",
                           o_covered_bases, o_read_hits);
                    n_fail++;
                end else begin
                    seen_counts = owed_counts.pop_front();
                    if (o_covered_bases !== seen_counts.covered) begin
                        $error("covered_bases: expected %0d, got %0d",
                               seen_counts.covered, o_covered_bases);
                        n_fail++;
                    end
                    if (o_read_hits !== seen_counts.hits) begin
                        $error("read_hits: expected %0d, got %0d",
                               seen_counts.hits, o_read_hits);
                        n_fail++;
                    end
                end
            end
            if (start && !busy) begin
                owed_counts.push_back(mark_coverage('{i_op, i_first_element, i_start_pos,
                                                      i_cigar_code, i_run_length}));
            end
        end
    end

    // watchdog: any handshake, result or config access counts as progress
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_req(input logic op, input logic first, input logic [14:0] pos,
                            input logic [3:0] code, input logic [14:0] run);
        pending_reqs.push_back('{op, first, pos, code, run});
    endtask

    // random cigar code, weighted toward marking runs
    function automatic logic [3:0] pick_code();
        int roll;
        roll = $urandom_range(19);
        if (roll < 8) return CIGAR_M;
        if (roll < 10) return (roll == 8) ? CIGAR_EQ : CIGAR_X;
        if (roll < 13) return (roll == 10) ? CIGAR_D : CIGAR_N;
        if (roll < 18) return logic'(roll[0]) ? CIGAR_I :
                              (roll == 14) ? CIGAR_S : (roll == 16) ? CIGAR_H : CIGAR_P;
        return 4'($urandom_range(9, 15));
    endfunction

    // mostly short runs, the odd zero or huge one
    function automatic logic [14:0] pick_run();
        int roll;
        roll = $urandom_range(99);
        if (roll < 2) return 15'($urandom);
        if (roll < 5) return 15'd0;
        return 15'($urandom_range(1, 120));
    endfunction

    // well-formed reads with random content, plus clears and raw noise
    task automatic queue_reads(input int n_items);
        int added;
        int span;
        int roll;
        int n_elems;
        added = 0;
        span  = (gene_len == 0) ? 200 : (gene_len > MAX_BASES) ? MAX_BASES : int'(gene_len);
        while (added < n_items) begin
            roll = $urandom_range(99);
            if (roll < 2) begin
                push_req(OP_CLEAR, 1'($urandom), 15'($urandom), 4'($urandom), 15'($urandom));
                added++;
            end else if (roll < 12) begin
                push_req(OP_ELEMENT, 1'($urandom), 15'($urandom), 4'($urandom), 15'($urandom));
                added++;
            end else begin
                n_elems = $urandom_range(1, 6);
                push_req(OP_ELEMENT, 1'b1, 15'($urandom_range(0, span + 20)),
                         pick_code(), pick_run());
                for (int k = 1; k < n_elems; k++) begin
                    push_req(OP_ELEMENT, 1'b0, 15'($urandom), pick_code(), pick_run());
                end
                added += n_elems;
            end
        end
    endtask

    // wait until every request is taken and every result is in
    task automatic drain();
        while (pending_reqs.size() != 0 || start || owed_counts.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // apb write of the target length followed by a read back
    task automatic write_target_len(input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TARGET_LEN_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        gene_len = value[14:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {17'd0, gene_len}) begin
            $error("target_len: expected %0d, got %0d", gene_len, prdata);
            n_fail++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    logic [31:0] gene_settings [8] = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd300,
                                       32'd16384, 32'd4096, 32'h0001_2345, 32'd16383};
    int          idle_settings [4] = '{0, 55, 0, 24};

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed opening at the reset gene length
        // element before any read start works from cursor zero
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_M, 15'd3);
        push_req(OP_ELEMENT, 1'b1, 15'd1, CIGAR_M, 15'd10);
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_M, 15'd0);
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_I, 15'd5);
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_S, 15'd5);
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_H, 15'd5);
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_P, 15'd5);
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_D, 15'd4);
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_N, 15'd4);
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_EQ, 15'd3);
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_X, 15'd3);
        // unused codes do nothing
        push_req(OP_ELEMENT, 1'b0, 15'd0, 4'd9, 15'd7);
        push_req(OP_ELEMENT, 1'b0, 15'd0, 4'd15, 15'h7FFF);
        // start position zero reads as base one
        push_req(OP_ELEMENT, 1'b1, 15'd0, CIGAR_M, 15'd4);
        // runs crossing and starting past the gene end
        push_req(OP_ELEMENT, 1'b1, 15'd16380, CIGAR_M, 15'd100);
        push_req(OP_ELEMENT, 1'b1, 15'd16385, CIGAR_EQ, 15'd10);
        push_req(OP_ELEMENT, 1'b1, 15'h7FFF, CIGAR_X, 15'h7FFF);
        // cursor saturation, then a run that must mark nothing
        push_req(OP_ELEMENT, 1'b1, 15'd30000, CIGAR_D, 15'h7FFF);
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_M, 15'd5);
        // clear ignores all other fields
        push_req(OP_CLEAR, 1'b1, 15'h7FFF, 4'hF, 15'h7FFF);
        // one read covering the whole gene, then a fully covered overlap
        push_req(OP_ELEMENT, 1'b1, 15'd1, CIGAR_M, 15'd16384);
        push_req(OP_ELEMENT, 1'b1, 15'd100, CIGAR_X, 15'd50);
        push_req(OP_CLEAR, 1'b0, 15'd0, CIGAR_M, 15'd0);
        push_req(OP_ELEMENT, 1'b0, 15'd0, CIGAR_M, 15'd2);
        drain();

        // random phases; no clear in between, so earlier marks outlive
        // each gene length change
        for (int ph = 0; ph < 8; ph++) begin
            write_target_len(gene_settings[ph]);
            idle_pct = idle_settings[ph % 4];
            @(negedge i_clk);
            queue_reads(62);
            drain();
        end

        // keep clocking to catch stray results
        repeat (50) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ccm_pkg.sv
sv/ccm_ram.sv
sv/ccm_ctrl.sv
sv/ccm_dpath.sv
sv/cigar_coverage_marker_core.sv
test/testbench.sv
